FILE: sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int INDEX_BITS  = 12;
   localparam int INDEX_LIMIT = 1 << INDEX_BITS;
   localparam int COORD_BITS  = 16;
   localparam int CORNERS     = 6;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_QUAD = 2'd1,
      OP_READ = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                        opcode;
      logic [INDEX_BITS-1:0]         index_a;
      logic [INDEX_BITS-1:0]         index_b;
      logic [INDEX_BITS-1:0]         index_c;
      logic [INDEX_BITS-1:0]         index_d;
      logic [INDEX_BITS-1:0]         index_e;
      logic [INDEX_BITS-1:0]         index_f;
      logic signed [COORD_BITS-1:0]  pos_x;
      logic signed [COORD_BITS-1:0]  pos_y;
      logic signed [COORD_BITS-1:0]  pos_z;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]         vertex_number;
      logic signed [COORD_BITS-1:0]  normal_x;
      logic signed [COORD_BITS-1:0]  normal_y;
      logic signed [COORD_BITS-1:0]  normal_z;
      logic                          degenerate;
   } rsp_type;

   // Classified command passed from the front end to the back end.
   typedef struct packed {
      op_type                                kind;
      logic [CORNERS-1:0][INDEX_BITS-1:0]    idx;
      logic [CORNERS-1:0]                    in_range;
      logic [3*COORD_BITS-1:0]               pos;
   } cmd_type;

endpackage

FILE: sv/vna_fifo.sv
// ----------------------------------------------------------------------------
// vna_fifo
// Small register-based first-in first-out queue.
// ----------------------------------------------------------------------------
module vna_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0]    mem [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS:0]   count_ff;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

FILE: sv/vna_front.sv
// ----------------------------------------------------------------------------
// vna_front
// Accepts request beats, drops no-ops and range-checks every index.
// ----------------------------------------------------------------------------
module vna_front #(
   parameter int VERTEX_COUNT = 4096
) (
   input  vna_pkg::req_type req_data,
   input  logic             req_push,
   output logic             req_full,
   input  logic             cmd_full,
   input  logic             clearing,
   output vna_pkg::cmd_type cmd_data,
   output logic             cmd_push
);
   import vna_pkg::*;

   logic [CORNERS-1:0][INDEX_BITS-1:0] idx;

   assign idx = {req_data.index_f, req_data.index_e, req_data.index_d,
                 req_data.index_c, req_data.index_b, req_data.index_a};

   assign req_full = cmd_full || clearing;
   assign cmd_push = req_push && !req_full && (req_data.opcode != OP_NOP);

   always_comb begin
      cmd_data.kind = req_data.opcode;
      cmd_data.idx  = idx;
      cmd_data.pos  = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
      for (int i = 0; i < CORNERS; i++) begin
         cmd_data.in_range[i] = (32'(idx[i]) < VERTEX_COUNT);
      end
   end
endmodule

FILE: sv/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// Iterative normalizer: prescale, sum of squares, square root, three divides.
// ----------------------------------------------------------------------------
module vna_norm #(
   parameter int SUM_BITS = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [vna_pkg::INDEX_BITS-1:0] vertex,
   input  logic signed [SUM_BITS-1:0]    sum_x,
   input  logic signed [SUM_BITS-1:0]    sum_y,
   input  logic signed [SUM_BITS-1:0]    sum_z,
   output logic                          done,
   output vna_pkg::rsp_type              result
);
   import vna_pkg::*;

   localparam int RED_BITS  = 30;
   localparam int SQ_BITS   = 62;
   localparam int ROOT_BITS = 31;
   localparam int Q_BITS    = 15;
   localparam int NUM_BITS  = RED_BITS + Q_BITS + 1;

   typedef enum logic [2:0] {
      N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DIV, N_DONE
   } state_type;

   state_type               state_ff;
   logic [SUM_BITS-1:0]     mag_ff [3];
   logic [2:0]              neg_ff;
   logic [1:0]              comp_ff;
   logic [3:0]              step_ff;
   logic [SQ_BITS-1:0]      sq_ff;
   logic [SQ_BITS-1:0]      x_ff;
   logic [SQ_BITS-1:0]      res_ff;
   logic [SQ_BITS-1:0]      bit_ff;
   logic [NUM_BITS-1:0]     rem_ff;
   logic [NUM_BITS-1:0]     dsh_ff;
   logic [Q_BITS-1:0]       q_ff;
   rsp_type                 result_ff;
   logic                    done_ff;

   logic [SUM_BITS-1:0]     mag_in [3];
   logic signed [SUM_BITS-1:0] sums [3];
   logic                    too_big;
   logic [2*RED_BITS-1:0]   square;
   logic [SQ_BITS-1:0]      trial;
   logic                    fits;
   logic [Q_BITS-1:0]       q_next;
   logic [COORD_BITS-1:0]   q_ext;
   logic [COORD_BITS-1:0]   signed_q;

   assign sums[0] = sum_x;
   assign sums[1] = sum_y;
   assign sums[2] = sum_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = sums[i][SUM_BITS-1] ? (~sums[i] + 1'b1) : sums[i];
      end
   end

   assign too_big  = (mag_ff[0][SUM_BITS-1:RED_BITS] != '0)
                  || (mag_ff[1][SUM_BITS-1:RED_BITS] != '0)
                  || (mag_ff[2][SUM_BITS-1:RED_BITS] != '0);
   assign square   = mag_ff[comp_ff][RED_BITS-1:0] * mag_ff[comp_ff][RED_BITS-1:0];
   assign trial    = res_ff + bit_ff;
   assign fits     = (rem_ff >= dsh_ff);
   assign q_next   = {q_ff[Q_BITS-2:0], fits};
   assign q_ext    = {1'b0, q_next};
   assign signed_q = neg_ff[comp_ff] ? (~q_ext + 1'b1) : q_ext;

   assign done   = done_ff;
   assign result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            N_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_in[i];
                     neg_ff[i] <= sums[i][SUM_BITS-1];
                  end
                  result_ff.vertex_number <= vertex;
                  result_ff.normal_x      <= '0;
                  result_ff.normal_y      <= '0;
                  result_ff.normal_z      <= '0;
                  if ((sum_x == '0) && (sum_y == '0) && (sum_z == '0)) begin
                     result_ff.degenerate <= 1'b1;
                     state_ff             <= N_DONE;
                  end else begin
                     result_ff.degenerate <= 1'b0;
                     state_ff             <= N_SHIFT;
                  end
               end
            end
            N_SHIFT: begin
               // All three magnitudes shift together until the largest fits.
               if (too_big) begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] >> 1;
                  end
               end else begin
                  comp_ff  <= '0;
                  sq_ff    <= '0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               sq_ff <= sq_ff + SQ_BITS'(square);
               if (comp_ff == 2'd2) begin
                  x_ff     <= sq_ff + SQ_BITS'(square);
                  res_ff   <= '0;
                  bit_ff   <= SQ_BITS'(1) << (SQ_BITS - 2);
                  state_ff <= N_ROOT;
               end else begin
                  comp_ff <= comp_ff + 1'b1;
               end
            end
            N_ROOT: begin
               if (x_ff >= trial) begin
                  x_ff   <= x_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  comp_ff  <= '0;
                  step_ff  <= '0;
                  state_ff <= N_DIV;
               end
            end
            N_DIV: begin
               if (step_ff == '0) begin
                  rem_ff  <= NUM_BITS'({mag_ff[comp_ff][RED_BITS-1:0], {Q_BITS{1'b0}}})
                           + NUM_BITS'(res_ff[ROOT_BITS-1:0]);
                  dsh_ff  <= {res_ff[ROOT_BITS-1:0], {Q_BITS{1'b0}}};
                  q_ff    <= '0;
                  step_ff <= step_ff + 1'b1;
               end else begin
                  if (fits) begin
                     rem_ff <= rem_ff - dsh_ff;
                  end
                  dsh_ff <= dsh_ff >> 1;
                  q_ff   <= q_next;
                  if (step_ff == 4'(Q_BITS)) begin
                     unique case (comp_ff)
                        2'd0:    result_ff.normal_x <= signed_q;
                        2'd1:    result_ff.normal_y <= signed_q;
                        default: result_ff.normal_z <= signed_q;
                     endcase
                     step_ff <= '0;
                     if (comp_ff == 2'd2) begin
                        state_ff <= N_DONE;
                     end else begin
                        comp_ff <= comp_ff + 1'b1;
                     end
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end
            end
            N_DONE: begin
               done_ff  <= 1'b1;
               state_ff <= N_IDLE;
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end
endmodule

FILE: sv/vna_back.sv
// ----------------------------------------------------------------------------
// vna_back
// Executes commands against the position and normal-sum memories.
// ----------------------------------------------------------------------------
module vna_back #(
   parameter int VERTEX_COUNT = 4096,
   parameter int SUM_BITS     = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  vna_pkg::cmd_type cmd_data,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output logic             clearing,
   output vna_pkg::rsp_type rsp_data,
   output logic             rsp_push,
   input  logic             rsp_full
);
   import vna_pkg::*;

   localparam int DEPTH     = (VERTEX_COUNT < INDEX_LIMIT) ? VERTEX_COUNT : INDEX_LIMIT;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int T_BITS    = PROD_BITS + 1;
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   typedef enum logic [3:0] {
      B_CLEAR, B_IDLE, B_FETCH, B_DIFF, B_MUL, B_ACC,
      B_RREAD, B_RSTART, B_RWAIT, B_RPUSH
   } state_type;

   logic [3*COORD_BITS-1:0] pos_mem [DEPTH];
   logic [3*SUM_BITS-1:0]   sum_mem [DEPTH];

   state_type                     state_ff;
   cmd_type                       cmd_ff;
   logic [ADDR_BITS-1:0]          clr_ff;
   logic [2:0]                    cnt_ff;
   logic                          phase_ff;
   logic [3*COORD_BITS-1:0]       pos_q_ff;
   logic                          pos_vld_ff;
   logic [3*SUM_BITS-1:0]         sum_q_ff;
   logic signed [COORD_BITS-1:0]  pt_ff [4][3];
   logic signed [DIFF_BITS-1:0]   u_ff [3];
   logic signed [DIFF_BITS-1:0]   r_ff [3];
   logic signed [DIFF_BITS-1:0]   w_ff [3];
   logic signed [PROD_BITS-1:0]   prod1_ff;
   logic signed [PROD_BITS-1:0]   prod2_ff;
   logic signed [T_BITS-1:0]      t_ff [6];
   rsp_type                       rsp_ff;

   logic [2:0]                    corner;
   logic [ADDR_BITS-1:0]          pos_ra;
   logic [ADDR_BITS-1:0]          sum_ra;
   logic                          sum_we;
   logic [ADDR_BITS-1:0]          sum_wa;
   logic [3*SUM_BITS-1:0]         sum_wd;
   logic                          pos_we;
   logic signed [DIFF_BITS-1:0]   op_a [3];
   logic signed [DIFF_BITS-1:0]   op_b [3];
   logic [1:0]                    c1;
   logic [1:0]                    c2;
   logic [3*SUM_BITS-1:0]         acc_wd;
   logic signed [SUM_BITS-1:0]    rd_sum [3];
   logic                          norm_start;
   logic                          norm_done;
   rsp_type                       norm_result;

   function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0] s,
      input logic signed [T_BITS-1:0]   t
   );
      logic signed [SUM_BITS:0] wide;
      wide = (SUM_BITS+1)'(s) + (SUM_BITS+1)'(t);
      if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
         sat_add = wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_add = wide[SUM_BITS-1:0];
      end
   endfunction

   // Corners fetched for a quad: A, B, C and the fourth corner F.
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    corner = 3'd0;
         2'd1:    corner = 3'd1;
         2'd2:    corner = 3'd2;
         default: corner = 3'd5;
      endcase
   end

   assign pos_ra = cmd_ff.idx[corner][ADDR_BITS-1:0];
   assign sum_ra = (state_ff == B_ACC) ? cmd_ff.idx[cnt_ff][ADDR_BITS-1:0]
                                       : cmd_ff.idx[0][ADDR_BITS-1:0];

   // First triangle is r x u, second is w x r.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         op_a[i] = (cnt_ff < 3'd3) ? r_ff[i] : w_ff[i];
         op_b[i] = (cnt_ff < 3'd3) ? u_ff[i] : r_ff[i];
      end
      unique case (cnt_ff)
         3'd0, 3'd3: begin c1 = 2'd1; c2 = 2'd2; end
         3'd1, 3'd4: begin c1 = 2'd2; c2 = 2'd0; end
         default:    begin c1 = 2'd0; c2 = 2'd1; end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_wd[i*SUM_BITS +: SUM_BITS] =
            sat_add(sum_q_ff[i*SUM_BITS +: SUM_BITS],
                    t_ff[(cnt_ff < 3'd3) ? i : i + 3]);
         rd_sum[i] = cmd_ff.in_range[0] ? sum_q_ff[i*SUM_BITS +: SUM_BITS] : '0;
      end
   end

   assign cmd_pop  = (state_ff == B_IDLE) && !cmd_empty;
   assign pos_we   = cmd_pop && (cmd_data.kind == OP_LOAD) && cmd_data.in_range[0];
   assign clearing = (state_ff == B_CLEAR);

   always_comb begin
      sum_we = 1'b0;
      sum_wa = cmd_data.idx[0][ADDR_BITS-1:0];
      sum_wd = '0;
      priority if (state_ff == B_CLEAR) begin
         sum_we = 1'b1;
         sum_wa = clr_ff;
      end else if (pos_we) begin
         sum_we = 1'b1;
      end else if ((state_ff == B_ACC) && phase_ff) begin
         sum_we = cmd_ff.in_range[cnt_ff];
         sum_wa = cmd_ff.idx[cnt_ff][ADDR_BITS-1:0];
         sum_wd = acc_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[cmd_data.idx[0][ADDR_BITS-1:0]] <= cmd_data.pos;
      end
      pos_q_ff   <= pos_mem[pos_ra];
      pos_vld_ff <= cmd_ff.in_range[corner];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      sum_q_ff <= sum_mem[sum_ra];
   end

   assign norm_start = (state_ff == B_RSTART);
   assign rsp_push   = (state_ff == B_RPUSH) && !rsp_full;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            B_CLEAR: begin
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= B_IDLE;
               end else begin
                  clr_ff <= clr_ff + 1'b1;
               end
            end
            B_IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff   <= cmd_data;
                  cnt_ff   <= '0;
                  phase_ff <= 1'b0;
                  unique case (cmd_data.kind)
                     OP_QUAD: state_ff <= B_FETCH;
                     OP_READ: state_ff <= B_RREAD;
                     default: state_ff <= B_IDLE;
                  endcase
               end
            end
            B_FETCH: begin
               if (cnt_ff != '0) begin
                  for (int i = 0; i < 3; i++) begin
                     pt_ff[cnt_ff[1:0] - 2'd1][i] <= pos_vld_ff
                        ? pos_q_ff[i*COORD_BITS +: COORD_BITS] : '0;
                  end
               end
               if (cnt_ff == 3'd4) begin
                  state_ff <= B_DIFF;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            B_DIFF: begin
               for (int i = 0; i < 3; i++) begin
                  u_ff[i] <= DIFF_BITS'(pt_ff[1][i]) - DIFF_BITS'(pt_ff[0][i]);
                  r_ff[i] <= DIFF_BITS'(pt_ff[2][i]) - DIFF_BITS'(pt_ff[0][i]);
                  w_ff[i] <= DIFF_BITS'(pt_ff[3][i]) - DIFF_BITS'(pt_ff[0][i]);
               end
               cnt_ff   <= '0;
               state_ff <= B_MUL;
            end
            B_MUL: begin
               // Products for one component; their difference is stored in the next cycle.
               prod1_ff <= op_a[c1] * op_b[c2];
               prod2_ff <= op_a[c2] * op_b[c1];
               if (cnt_ff != '0) begin
                  t_ff[cnt_ff - 3'd1] <= T_BITS'(prod1_ff) - T_BITS'(prod2_ff);
               end
               if (cnt_ff == 3'd6) begin
                  cnt_ff   <= '0;
                  phase_ff <= 1'b0;
                  state_ff <= B_ACC;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            B_ACC: begin
               phase_ff <= !phase_ff;
               if (phase_ff) begin
                  if (cnt_ff == 3'd5) begin
                     state_ff <= B_IDLE;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            B_RREAD:  state_ff <= B_RSTART;
            B_RSTART: state_ff <= B_RWAIT;
            B_RWAIT: begin
               if (norm_done) begin
                  rsp_ff   <= norm_result;
                  state_ff <= B_RPUSH;
               end
            end
            B_RPUSH: begin
               if (!rsp_full) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   vna_norm #(
      .SUM_BITS (SUM_BITS)
   ) u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .vertex (cmd_ff.idx[0]),
      .sum_x  (rd_sum[0]),
      .sum_y  (rd_sum[1]),
      .sum_z  (rd_sum[2]),
      .done   (norm_done),
      .result (norm_result)
   );
endmodule

FILE: sv/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted vertex normals for quad meshes with a front/back command queue.
// ----------------------------------------------------------------------------
// A load stores its position and clears its sum entry; a quad makes 4 position
// reads, 7 multiply steps and 6 read-modify-write updates on the sum memory.
// A read of a zero sum skips the arithmetic; otherwise it prescales (at most
// SUM_BITS - 30 shifts), then runs the square root and three divides. After
// reset the sum memory is cleared one entry per cycle (VERTEX_COUNT entries,
// at most 4096), during which req_full stays high.
module vertex_normal_accumulator #(
   parameter int VERTEX_COUNT = 4096,
   parameter int SUM_BITS     = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  vna_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output vna_pkg::rsp_type rsp_data
);
   import vna_pkg::*;

   cmd_type cmd_in;
   cmd_type cmd_head;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;
   logic    clearing;
   logic [$bits(cmd_type)-1:0] cmd_raw;
   logic [$bits(rsp_type)-1:0] rsp_raw;
   rsp_type back_rsp;
   logic    back_push;
   logic    rsp_full;

   vna_front #(
      .VERTEX_COUNT (VERTEX_COUNT)
   ) u_front (
      .req_data (req_data),
      .req_push (req_push),
      .req_full (req_full),
      .cmd_full (cmd_full),
      .clearing (clearing),
      .cmd_data (cmd_in),
      .cmd_push (cmd_push)
   );

   vna_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (4)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_raw),
      .empty     (cmd_empty)
   );

   assign cmd_head = cmd_type'(cmd_raw);

   vna_back #(
      .VERTEX_COUNT (VERTEX_COUNT),
      .SUM_BITS     (SUM_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .rsp_data  (back_rsp),
      .rsp_push  (back_push),
      .rsp_full  (rsp_full)
   );

   vna_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_raw),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_raw);
endmodule

FILE: verif/vertex_normal_accumulator_tb.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_tb
// Self-checking bench: loads, quads and reads are pushed with random gaps, and
// a scoreboard mirrors the position store and the saturating normal sums to
// predict every normalized read, which is compared field by field.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_tb;
   import vna_pkg::*;

   localparam int   MESH_SIZE  = 4096;
   localparam int   SUM_WIDTH  = 40;
   localparam int   CYCLE_CAP  = 2000000;
   localparam int   ITEM_TOTAL = 1200;

   class normal_scoreboard;
      logic signed [COORD_BITS-1:0] position [MESH_SIZE][3];
      longint                       sums [MESH_SIZE][3];
      rsp_type                      pending_normals [$];
      int                           mismatches;
      int                           checked;
      int                           degenerate_seen;

      function automatic longint add_saturated(longint acc, longint delta);
         longint top;
         longint bottom;
         top    = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
         bottom = -top - 1;
         if (delta > 0 && acc > top - delta) return top;
         if (delta < 0 && acc < bottom - delta) return bottom;
         return acc + delta;
      endfunction

      function automatic longint unsigned root_floor(longint unsigned x);
         longint unsigned res;
         longint unsigned bit_val;
         res = 0;
         bit_val = 64'd1 << 62;
         while (bit_val > x) bit_val >>= 2;
         while (bit_val != 0) begin
            if (x >= res + bit_val) begin
               x -= res + bit_val;
               res = (res >> 1) + bit_val;
            end else begin
               res >>= 1;
            end
            bit_val >>= 2;
         end
         return res;
      endfunction

      function automatic void add_to_vertex(logic [INDEX_BITS-1:0] v, longint t[3]);
         for (int i = 0; i < 3; i++) sums[v][i] = add_saturated(sums[v][i], t[i]);
      endfunction

      function automatic void note_request(req_type item);
         longint pa[3], pb[3], pc[3], pf[3], u[3], r[3], w[3], t1[3], t2[3];
         longint unsigned mag[3], peak, square_sum, len, n;
         int shift;
         rsp_type exp_normal;
         case (item.opcode)
            OP_LOAD: begin
               position[item.index_a][0] = item.pos_x;
               position[item.index_a][1] = item.pos_y;
               position[item.index_a][2] = item.pos_z;
               for (int i = 0; i < 3; i++) sums[item.index_a][i] = 0;
            end
            OP_QUAD: begin
               for (int i = 0; i < 3; i++) begin
                  pa[i] = position[item.index_a][i];
                  pb[i] = position[item.index_b][i];
                  pc[i] = position[item.index_c][i];
                  pf[i] = position[item.index_f][i];
                  u[i] = pb[i] - pa[i];
                  r[i] = pc[i] - pa[i];
                  w[i] = pf[i] - pa[i];
               end
               t1[0] = r[1] * u[2] - r[2] * u[1];
               t1[1] = r[2] * u[0] - r[0] * u[2];
               t1[2] = r[0] * u[1] - r[1] * u[0];
               t2[0] = w[1] * r[2] - w[2] * r[1];
               t2[1] = w[2] * r[0] - w[0] * r[2];
               t2[2] = w[0] * r[1] - w[1] * r[0];
               add_to_vertex(item.index_a, t1);
               add_to_vertex(item.index_b, t1);
               add_to_vertex(item.index_c, t1);
               add_to_vertex(item.index_d, t2);
               add_to_vertex(item.index_e, t2);
               add_to_vertex(item.index_f, t2);
            end
            OP_READ: begin
               exp_normal = '0;
               exp_normal.vertex_number = item.index_a;
               peak = 0;
               for (int i = 0; i < 3; i++) begin
                  mag[i] = (sums[item.index_a][i] < 0) ? -sums[item.index_a][i]
                                                       : sums[item.index_a][i];
                  if (mag[i] > peak) peak = mag[i];
               end
               if (peak == 0) begin
                  exp_normal.degenerate = 1'b1;
               end else begin
                  // Scale the largest component below 2^30 so the squares fit.
                  shift = 0;
                  while ((peak >> shift) >= (64'd1 << 30)) shift++;
                  square_sum = 0;
                  for (int i = 0; i < 3; i++) begin
                     mag[i] >>= shift;
                     square_sum += mag[i] * mag[i];
                  end
                  len = root_floor(square_sum);
                  for (int i = 0; i < 3; i++) begin
                     n = (mag[i] * 32768 + len) / (2 * len);
                     if (sums[item.index_a][i] < 0) n = -n;
                     case (i)
                        0: exp_normal.normal_x = n[15:0];
                        1: exp_normal.normal_y = n[15:0];
                        default: exp_normal.normal_z = n[15:0];
                     endcase
                  end
               end
               pending_normals = {pending_normals, exp_normal};
            end
            default: ;
         endcase
      endfunction

      function automatic void check_response(rsp_type got);
         rsp_type want;
         checked++;
         if (pending_normals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result for vertex %0d", got.vertex_number);
            return;
         end
         want = pending_normals.pop_front();
         if (want.degenerate) degenerate_seen++;
         if (got.vertex_number !== want.vertex_number || got.normal_x !== want.normal_x ||
             got.normal_y !== want.normal_y || got.normal_z !== want.normal_z ||
             got.degenerate !== want.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: expected v=%0d n=(%0d,%0d,%0d) deg=%0b, got v=%0d n=(%0d,%0d,%0d) deg=%0b",
                        want.vertex_number, want.normal_x, want.normal_y, want.normal_z,
                        want.degenerate, got.vertex_number, got.normal_x, got.normal_y,
                        got.normal_z, got.degenerate);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   normal_scoreboard normals;
   int      cycle_count;
   int      beats_in;
   int      op_counts [4];
   int      loaded_list [$];
   bit      is_loaded [MESH_SIZE];

   vertex_normal_accumulator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Pushes one beat after a random gap; push stays high across back-to-back beats.
   task automatic send_item(req_type item);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      normals.note_request(item);
      op_counts[item.opcode]++;
      beats_in++;
      if (item.opcode == OP_LOAD && !is_loaded[item.index_a]) begin
         is_loaded[item.index_a] = 1'b1;
         loaded_list = {loaded_list, int'(item.index_a)};
      end
   endtask

   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic req_type make_load(int v);
      req_type item;
      item = '0;
      item.opcode  = OP_LOAD;
      item.index_a = INDEX_BITS'(v);
      item.index_b = INDEX_BITS'($urandom);
      item.index_c = INDEX_BITS'($urandom);
      item.index_d = INDEX_BITS'($urandom);
      item.index_e = INDEX_BITS'($urandom);
      item.index_f = INDEX_BITS'($urandom);
      item.pos_x   = pick_coord();
      item.pos_y   = pick_coord();
      item.pos_z   = pick_coord();
      return item;
   endfunction

   function automatic req_type make_quad(int a, int b, int c, int d, int e, int f);
      req_type item;
      item = '0;
      item.opcode = OP_QUAD;
      item.index_a = INDEX_BITS'(a); item.index_b = INDEX_BITS'(b);
      item.index_c = INDEX_BITS'(c); item.index_d = INDEX_BITS'(d);
      item.index_e = INDEX_BITS'(e); item.index_f = INDEX_BITS'(f);
      item.pos_x = COORD_BITS'($urandom);
      item.pos_y = COORD_BITS'($urandom);
      item.pos_z = COORD_BITS'($urandom);
      return item;
   endfunction

   function automatic req_type make_read(int v);
      req_type item;
      item = make_quad(v, $urandom, $urandom, $urandom, $urandom, $urandom);
      item.opcode = OP_READ;
      return item;
   endfunction

   function automatic int some_loaded();
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   // Result side: random pop gaps, plus one long hold-off so the block backs up.
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      rsp_pop <= 1'b0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (!held && beats_in >= 400) gap = gap + 3000;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
            if (gap >= 3000) held = 1'b1;
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         normals.check_response(rsp_data);
      end
   end

   initial begin
      req_type item;
      int      a, b, c, f, choice;
      normals = new();
      cycle_count = 0;
      beats_in = 0;
      reset    <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme corners, unused opcode, repeated and reordered indices.
      item = make_load(0);
      item.pos_x = 16'sh8000; item.pos_y = 16'sh8000; item.pos_z = 16'sh7FFF;
      send_item(item);
      item = make_load(1);
      item.pos_x = 16'sh7FFF; item.pos_y = 16'sh8000; item.pos_z = 16'sh8000;
      send_item(item);
      item = make_load(2);
      item.pos_x = 16'sh8000; item.pos_y = 16'sh7FFF; item.pos_z = 16'sh0000;
      send_item(item);
      send_item(make_load(3));
      send_item(make_load(4095));
      send_item(make_quad(0, 1, 2, 0, 2, 3));
      for (int v = 0; v < 4; v++) send_item(make_read(v));
      send_item(make_read(4095));
      send_item(make_read(2730));
      item = make_read(0);
      item.opcode = OP_NOP;
      send_item(item);
      send_item(make_quad(0, 0, 1, 0, 1, 1));
      send_item(make_quad(3, 2, 1, 4095, 2048, 0));
      send_item(make_quad(4095, 1, 2, 3, 3, 3));
      send_item(make_read(0));
      send_item(make_read(2048));
      send_item(make_read(4095));
      send_item(make_load(0));
      send_item(make_read(0));

      // Random mix over a small working set so sums build up between reloads.
      for (int n = 0; n < ITEM_TOTAL; n++) begin
         if (n == 600) begin
            // Hammer one large quad until its sums saturate.
            for (int k = 0; k < 70; k++) send_item(make_quad(0, 1, 2, 0, 0, 3));
            for (int v = 0; v < 4; v++) send_item(make_read(v));
         end
         choice = $urandom_range(0, 99);
         if (choice < 25) begin
            send_item(make_load(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                             : $urandom_range(0, 31)));
         end else if (choice < 72) begin
            a = some_loaded(); b = some_loaded(); c = some_loaded(); f = some_loaded();
            if ($urandom_range(0, 4) != 0)
               send_item(make_quad(a, b, c, a, c, f));
            else
               send_item(make_quad(a, b, c, $urandom_range(0, 4095), some_loaded(), f));
         end else if (choice < 96) begin
            send_item(make_read(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                                             : some_loaded()));
         end else begin
            item = make_read($urandom);
            item.opcode = OP_NOP;
            send_item(item);
         end
      end
      req_push <= 1'b0;

      while (normals.pending_normals.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Sent %0d beats: %0d loads, %0d quads, %0d reads, %0d no-ops.",
               beats_in, op_counts[OP_LOAD], op_counts[OP_QUAD], op_counts[OP_READ],
               op_counts[OP_NOP]);
      $display("Checked %0d normals, %0d of them degenerate; %0d mismatches.",
               normals.checked, normals.degenerate_seen, normals.mismatches);
      if (normals.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
sv/vna_pkg.sv
sv/vna_fifo.sv
sv/vna_front.sv
sv/vna_norm.sv
sv/vna_back.sv
sv/vertex_normal_accumulator.sv
verif/vertex_normal_accumulator_tb.sv
